// ===== hw/rtl/psh_pkg.sv =====
// Shared constants, types and helpers of the pair-sum hash detector.
package psh_pkg;

  // Field widths fixed by the stream format
  localparam int VALUE_W  = 32;
  localparam int TARGET_W = 33;

  // Hash table geometry; the home slot is the low value bits, so the depth is a power of two
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Set tag stored beside each value; tag zero never marks a live entry
  localparam int TAG_W = 8;
  localparam logic [TAG_W-1:0] TAG_NONE  = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;

  // Width of the result beat payload
  localparam int OUT_DATA_W = 8;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   we;
    addr_t  addr;
    entry_t data;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_INS,
    ST_EMIT
  } state_t;

  // Home slot of a value: its low bits
  function automatic addr_t home_slot(input logic [VALUE_W-1:0] v);
    return v[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/psh_table.sv =====
// Single-port hash table memory holding tagged values, with registered read data.
module psh_table (
  input  logic              clk,
  input  psh_pkg::mem_req_t req,
  output psh_pkg::entry_t   rd_q
);

  psh_pkg::entry_t mem [psh_pkg::TABLE_DEPTH];

  // One access a cycle: either a write or a read whose data appears next cycle.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.data;
      end else begin
        rd_q <= mem[req.addr];
      end
    end
  end

endmodule

// ===== hw/rtl/psh_ctrl.sv =====
// Probe sequencer: complement lookup, insert, set tagging and table clearing.
module psh_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic        [psh_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_last,
  input  logic signed [psh_pkg::TARGET_W-1:0] target,
  output psh_pkg::mem_req_t                  req,
  input  psh_pkg::entry_t                    rd_q,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic                               res_found,
  output logic                               res_full
);

  psh_pkg::state_t              state_r, state_nxt;
  logic [psh_pkg::ADDR_W-1:0]   cnt_r;
  logic [psh_pkg::TAG_W-1:0]    epoch_r;
  logic                         match_r;
  logic                         ovf_r;
  psh_pkg::addr_t               slot_r;
  logic [psh_pkg::VALUE_W-1:0]  val_r;
  logic [psh_pkg::VALUE_W-1:0]  comp_r;
  logic                         last_r;

  logic signed [psh_pkg::TARGET_W:0] comp_full;
  logic                         comp_ok;
  psh_pkg::addr_t               first_addr;
  logic [psh_pkg::VALUE_W-1:0]  key;
  logic                         used;
  logic                         hit;
  logic                         exhaust;
  logic                         step;

  // Complement target minus value, and whether it fits the value range.
  assign comp_full = $signed({target[psh_pkg::TARGET_W-1], target})
                   - $signed({{2{in_value[psh_pkg::VALUE_W-1]}}, in_value});
  assign comp_ok   = (comp_full[psh_pkg::TARGET_W] == comp_full[psh_pkg::TARGET_W-1]) &&
                     (comp_full[psh_pkg::TARGET_W-1] == comp_full[psh_pkg::VALUE_W-1]);
  assign first_addr = comp_ok ? psh_pkg::home_slot(comp_full[psh_pkg::VALUE_W-1:0])
                              : psh_pkg::home_slot(in_value);

  // Compare the entry read last cycle against the key of the current probe run.
  assign key     = (state_r == psh_pkg::ST_LOOK) ? comp_r : val_r;
  assign used    = (rd_q.tag == epoch_r);
  assign hit     = used && (rd_q.value == key);
  assign exhaust = used && !hit && (cnt_r == psh_pkg::ADDR_W'(psh_pkg::TABLE_DEPTH - 1));
  assign step    = used && !hit && !exhaust;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psh_pkg::ST_CLEAR: begin
        if (cnt_r == psh_pkg::ADDR_W'(psh_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = psh_pkg::ST_IDLE;
        end
      end
      psh_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = comp_ok ? psh_pkg::ST_LOOK : psh_pkg::ST_INS;
        end
      end
      psh_pkg::ST_LOOK: begin
        if (!step) begin
          state_nxt = psh_pkg::ST_INS;
        end
      end
      psh_pkg::ST_INS: begin
        if (!step) begin
          state_nxt = last_r ? psh_pkg::ST_EMIT : psh_pkg::ST_IDLE;
        end
      end
      psh_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_nxt = (epoch_r == psh_pkg::TAG_LAST) ? psh_pkg::ST_CLEAR : psh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psh_pkg::ST_CLEAR;
    endcase
  end

  // Memory requests, handshake and result strobe.
  always_comb begin
    in_tready       = 1'b0;
    res_valid       = 1'b0;
    req.en          = 1'b0;
    req.we          = 1'b0;
    req.addr        = slot_r + psh_pkg::ADDR_W'(1);
    req.data.tag    = epoch_r;
    req.data.value  = val_r;
    unique case (state_r)
      psh_pkg::ST_CLEAR: begin
        req.en         = 1'b1;
        req.we         = 1'b1;
        req.addr       = cnt_r;
        req.data.tag   = psh_pkg::TAG_NONE;
        req.data.value = '0;
      end
      psh_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        req.en    = in_tvalid;
        req.addr  = first_addr;
      end
      psh_pkg::ST_LOOK: begin
        req.en = 1'b1;
        if (!step) begin
          req.addr = psh_pkg::home_slot(val_r);
        end
      end
      psh_pkg::ST_INS: begin
        if (step) begin
          req.en = 1'b1;
        end else if (!used) begin
          // Free slot on the probe path: store the value there.
          req.en   = 1'b1;
          req.we   = 1'b1;
          req.addr = slot_r;
        end
      end
      psh_pkg::ST_EMIT: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_found = match_r;
  assign res_full  = ovf_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psh_pkg::ST_CLEAR;
      cnt_r   <= '0;
      epoch_r <= psh_pkg::TAG_FIRST;
      match_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        psh_pkg::ST_CLEAR: begin
          cnt_r <= cnt_r + psh_pkg::ADDR_W'(1);
          if (state_nxt == psh_pkg::ST_IDLE) begin
            epoch_r <= psh_pkg::TAG_FIRST;
          end
        end
        psh_pkg::ST_IDLE: begin
          cnt_r <= '0;
        end
        psh_pkg::ST_LOOK: begin
          if (step) begin
            cnt_r <= cnt_r + psh_pkg::ADDR_W'(1);
          end else begin
            cnt_r   <= '0;
            match_r <= match_r | hit;
          end
        end
        psh_pkg::ST_INS: begin
          if (step) begin
            cnt_r <= cnt_r + psh_pkg::ADDR_W'(1);
          end else begin
            cnt_r <= '0;
            ovf_r <= ovf_r | exhaust;
          end
        end
        psh_pkg::ST_EMIT: begin
          if (res_ready) begin
            match_r <= 1'b0;
            ovf_r   <= 1'b0;
            cnt_r   <= '0;
            if (epoch_r != psh_pkg::TAG_LAST) begin
              epoch_r <= epoch_r + psh_pkg::TAG_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload and probe position.
  always_ff @(posedge clk) begin
    unique case (state_r)
      psh_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          val_r  <= in_value;
          last_r <= in_last;
          comp_r <= comp_full[psh_pkg::VALUE_W-1:0];
          slot_r <= first_addr;
        end
      end
      psh_pkg::ST_LOOK: begin
        slot_r <= step ? slot_r + psh_pkg::ADDR_W'(1) : psh_pkg::home_slot(val_r);
      end
      psh_pkg::ST_INS: begin
        if (step) begin
          slot_r <= slot_r + psh_pkg::ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pair_sum_hash_detector.sv =====
// An item is taken only in the idle state; then its complement, if in range, and its own
// insert are probed slot by slot on the single-port table memory before another item is taken.
// After the last item of a set, the emit state hands its result beat to the output register.
// Reset (rst_n low, synchronous) clears all flags and starts a clearing pass over all 1024
// table slots; the same pass follows every 255th set. No beat is accepted during the pass.
module pair_sum_hash_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [psh_pkg::VALUE_W-1:0]       in_tdata,   // [31:0] value
  input  logic                              in_tlast,   // last_item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [psh_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] pair_found, [1] table_full
  input  logic                              cfg_we,
  input  logic [psh_pkg::TARGET_W-1:0]      cfg_wdata   // target_sum
);

  logic signed [psh_pkg::TARGET_W-1:0] target_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic              out_full_r;
  logic              res_valid;
  logic              res_ready;
  logic              res_found;
  logic              res_full;
  psh_pkg::mem_req_t req;
  psh_pkg::entry_t   rd_q;

  // Target sum register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= $signed(cfg_wdata);
    end
  end

  psh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .target    (target_r),
    .req       (req),
    .rd_q      (rd_q),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_found (res_found),
    .res_full  (res_full)
  );

  psh_table u_table (
    .clk  (clk),
    .req  (req),
    .rd_q (rd_q)
  );

  // Output register: the result waits here while new items are processed.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_found_r <= res_found;
      out_full_r  <= res_full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(psh_pkg::OUT_DATA_W - 2){1'b0}}, out_full_r, out_found_r};

endmodule

// ===== hw/rtl/psh_checker.sv =====
// Port-level checks on the pair-sum hash detector, bound to the top level.
module psh_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [psh_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Padding bits of the result beat stay zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[psh_pkg::OUT_DATA_W-1:2] == '0)
    else $error("result padding bits not zero");

  // The engine is busy probing in the cycle after it takes a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("beat accepted while a probe run was due");

  // Leaving reset starts the clearing pass, so no beat is taken at once.
  a_clear: assert property (@(posedge clk)
    rst_n && $past(rst_n) == 1'b0 |-> !in_tready)
    else $error("input ready during table clearing");

endmodule

bind pair_sum_hash_detector psh_checker u_psh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/pair_sum_checker.sv =====
// Checker for the pair-sum hash detector: watches all channels, predicts and compares outcomes.
`timescale 1ns / 100ps

module pair_sum_checker
  import psh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,    // [31:0] value
  input  logic                  in_tlast,    // last_item
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,   // [0] pair_found, [1] table_full
  input  logic                  cfg_we,
  input  logic [TARGET_W-1:0]   cfg_wdata,   // target_sum
  output int                    fail_count,
  output int                    results_owed,
  output int                    results_checked
);

  localparam int DEPTH = TABLE_DEPTH;
  localparam longint VAL_MIN = -(64'sd1 <<< (VALUE_W - 1));
  localparam longint VAL_MAX = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;

  typedef struct packed {
    logic pair_found;
    logic table_full;
  } set_outcome_t;

  // Shadow copy of the hash set and the per-set flags.
  logic [VALUE_W-1:0]         slot_val  [DEPTH];
  bit                         slot_busy [DEPTH];
  bit                         hit_flag;
  bit                         full_flag;
  logic signed [TARGET_W-1:0] target_q;

  set_outcome_t outcome_q[$];
  int           fails;
  int           checked;

  // Empties the shadow table between sets.
  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) begin
      slot_busy[i] = 1'b0;
      slot_val[i]  = '0;
    end
    hit_flag  = 1'b0;
    full_flag = 1'b0;
  endfunction

  // Linear probe from the home slot. Returns 1 when the key is stored; otherwise free_idx
  // holds the first free slot on the path, or -1 when every slot is taken.
  function automatic bit probe_for(input logic [VALUE_W-1:0] key, output int free_idx);
    int idx;
    free_idx = -1;
    idx = int'(key % VALUE_W'(DEPTH));
    for (int n = 0; n < DEPTH; n++) begin
      if (!slot_busy[idx]) begin
        free_idx = idx;
        return 1'b0;
      end
      if (slot_val[idx] == key) return 1'b1;
      idx = (idx + 1) % DEPTH;
    end
    return 1'b0;
  endfunction

  // Looks up the complement of one value, then stores the value if it is new.
  function automatic void absorb_value(input logic [VALUE_W-1:0] v);
    logic signed [VALUE_W-1:0] sv;
    longint comp;
    int free_idx;
    sv = v;
    comp = longint'(target_q) - longint'(sv);
    // A complement outside the value range cannot be stored, so it never matches.
    if (comp >= VAL_MIN && comp <= VAL_MAX) begin
      if (probe_for(VALUE_W'(comp), free_idx)) hit_flag = 1'b1;
    end
    if (!probe_for(v, free_idx)) begin
      if (free_idx >= 0) begin
        slot_busy[free_idx] = 1'b1;
        slot_val[free_idx]  = v;
      end else begin
        full_flag = 1'b1;
      end
    end
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
    wipe_table();
  end

  // Register writes, input beats and result beats, all sampled at the rising edge.
  always @(posedge clk) begin
    set_outcome_t want;
    if (!rst_n) begin
      target_q = '0;
      wipe_table();
      outcome_q.delete();
    end else begin
      if (cfg_we) target_q = cfg_wdata;

      if (in_tvalid && in_tready) begin
        absorb_value(in_tdata);
        if (in_tlast) begin
          want.pair_found = hit_flag;
          want.table_full = full_flag;
          outcome_q.push_back(want);
          wipe_table();
        end
      end

      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, got found=%0b full=%0b",
                   $time, out_tdata[0], out_tdata[1]);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (out_tdata[0] !== want.pair_found) begin
            $display("%0t ns: pair_found expected %0b, got %0b",
                     $time, want.pair_found, out_tdata[0]);
            fails++;
          end
          if (out_tdata[1] !== want.table_full) begin
            $display("%0t ns: table_full expected %0b, got %0b",
                     $time, want.table_full, out_tdata[1]);
            fails++;
          end
        end
      end
    end
    fail_count      <= fails;
    results_owed    <= outcome_q.size();
    results_checked <= checked;
  end

endmodule

// ===== verif/pair_sum_hash_detector_tb.sv =====
// Testbench top for the pair-sum hash detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module pair_sum_hash_detector_tb;
  import psh_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 16;
  localparam longint VAL_MIN = -(64'sd1 <<< (VALUE_W - 1));
  localparam longint VAL_MAX = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
  localparam logic signed [TARGET_W-1:0] TGT_MAX = 33'sh0_FFFF_FFFE;
  localparam logic signed [TARGET_W-1:0] TGT_MIN = 33'sh1_0000_0000;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata   = '0;   // [31:0] value
  logic                  in_tlast   = 1'b0; // last_item
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [0] pair_found, [1] table_full
  logic                  cfg_we     = 1'b0;
  logic [TARGET_W-1:0]   cfg_wdata  = '0;   // target_sum

  int fail_count;
  int results_owed;
  int results_checked;

  longint             cur_target;
  logic [VALUE_W-1:0] set_vals[$];
  logic [VALUE_W-1:0] recent_vals[$];
  bit                 sender_steady;
  int                 values_sent;
  int                 sets_sent;
  int                 targets_used;
  int                 quiet_cycles;

  pair_sum_hash_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  pair_sum_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Sends one value beat and returns at the edge where it is taken.
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic is_last);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    values_sent++;
    if (is_last) sets_sent++;
  endtask

  // A short set of up to four values for the directed part.
  task automatic send_set(input int n, input logic [VALUE_W-1:0] a,
                          input logic [VALUE_W-1:0] b = '0,
                          input logic [VALUE_W-1:0] c = '0,
                          input logic [VALUE_W-1:0] d = '0);
    logic [VALUE_W-1:0] v [4];
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    for (int i = 0; i < n; i++) send_value(v[i], i == n - 1);
  endtask

  // Holds the sender back until every outstanding set outcome has come out.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Writes a new target once the block has gone quiet.
  task automatic retarget(input logic signed [TARGET_W-1:0] t);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= t;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_target = longint'(t);
    targets_used++;
  endtask

  function automatic logic signed [TARGET_W-1:0] pick_target();
    logic signed [TARGET_W-1:0] t;
    case ($urandom_range(0, 6))
      0: t = '0;
      1: t = TGT_MAX;
      2: t = TGT_MIN;
      3: t = '1;
      4: t = TARGET_W'(signed'($urandom_range(0, 8192)) - 4096);
      5: t = {1'($urandom_range(0, 1)), 32'($urandom)};
      default: t = TARGET_W'(longint'(signed'(32'($urandom)))
                             + longint'(signed'(32'($urandom))));
    endcase
    // The sum of two values never exceeds the largest positive target.
    if (t == 33'sh0_FFFF_FFFF) t = TGT_MAX;
    return t;
  endfunction

  // Biased towards complements, duplicates and hash collisions within the set,
  // values from earlier sets, and the edges of the value range.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    int k;
    longint comp;
    logic signed [VALUE_W-1:0] base;
    r = $urandom_range(0, 99);
    if (set_vals.size() > 0) begin
      k = $urandom_range(0, set_vals.size() - 1);
      base = set_vals[k];
      if (r < 30) begin
        comp = cur_target - longint'(base);
        if (comp >= VAL_MIN && comp <= VAL_MAX) return VALUE_W'(comp);
        return $urandom;
      end
      if (r < 42) return base;
      if (r < 56) return base + VALUE_W'($urandom_range(1, 7) * DEPTH);
    end
    if (r < 66 && recent_vals.size() > 0)
      return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    if (r < 76) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if (r < 86) return VALUE_W'($urandom_range(0, 4095)) - VALUE_W'(2048);
    return $urandom;
  endfunction

  // Mostly very short sets, so that many sets fit into the run.
  function automatic int pick_set_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 85) return $urandom_range(2, 3);
    if (r < 97) return $urandom_range(4, 6);
    return $urandom_range(7, 16);
  endfunction

  // Result side: ready in runs, with stalls of random length between them.
  initial begin
    int run;
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      run = $urandom_range(1, 16);
      repeat (run) @(posedge clk);
      run = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      if (run > 0) begin
        out_tready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    quiet_cycles  = 0;
    cur_target    = 0;
    sender_steady = 1'b0;
    values_sent   = 0;
    sets_sent     = 0;
    targets_used  = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets under the reset target of zero: a lone value, a pair at the
    // range edges, and a complement that would match only if truncated.
    send_set(1, 32'h0000_0000);
    send_set(2, 32'h7FFF_FFFF, 32'h8000_0001);
    send_set(2, 32'h8000_0000, 32'h8000_0000);

    // Small target: a value must not pair with itself, repeats may, and inserts
    // have to walk a chain of colliding values.
    retarget(33'sd10);
    send_set(2, 32'd5, 32'd5);
    send_set(3, 32'd5, 32'd3, 32'd4);
    send_set(4, 32'd1, 32'd1025, 32'd2049, 32'd9);

    // Largest and smallest targets, where some complements fall out of range, then a target of minus one.
    retarget(TGT_MAX);
    send_set(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_set(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    retarget(TGT_MIN);
    send_set(2, 32'h0000_0000, 32'h0000_0000);
    send_set(2, 32'h8000_0000, 32'h8000_0000);
    retarget('1);
    send_set(2, 32'h5555_5555, 32'hAAAA_AAAA);

    // Random sets, with the target changed every few dozen sets and enough sets
    // to carry the block through its periodic table clear.
    retarget(pick_target());
    while (sets_sent < 260) begin
      if (sets_sent % 40 == 0) retarget(pick_target());
      if ($urandom_range(0, 19) == 0) wait_for_results();
      sender_steady = ($urandom_range(0, 3) == 0);
      set_vals.delete();
      len = pick_set_len();
      for (int j = 0; j < len; j++) begin
        set_vals.push_back(pick_value());
        send_value(set_vals[j], j == len - 1);
      end
      foreach (set_vals[j]) recent_vals.push_back(set_vals[j]);
      while (recent_vals.size() > 64) void'(recent_vals.pop_front());
    end

    wait_for_results();
    repeat (64) @(posedge clk);

    $display("Run covered %0d values in %0d sets under %0d target writes,",
             values_sent, sets_sent, targets_used);
    $display("running past the periodic table clear; %0d set outcomes compared.",
             results_checked);
    if (results_owed != 0) $display("%0d set outcomes never arrived", results_owed);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
